// ----- src/tc_pkg.sv -----
// Package for the triangle circumcircle block: widths, register codes and
// the sideband structs that travel with the pipeline. No dependencies.
`default_nettype none
package tc_pkg;

    localparam int CW    = 24;           // vertex coordinate width
    localparam int FB    = 8;            // fraction bits
    localparam int DW    = CW + 1;       // vertex difference width
    localparam int PW    = 2 * DW;       // product of two differences
    localparam int DETW  = PW + 2;       // determinant width, signed
    localparam int SQW   = PW;           // squared length, unsigned
    localparam int BL    = 32;           // low part of a split operand
    localparam int BH    = SQW - BL;     // high part of a squared length
    localparam int PLW   = BL + 1 + DW;  // low partial product width
    localparam int PHW   = BH + 1 + DW;  // high partial product width
    localparam int NW    = SQW + DW + 1; // numerator width, signed
    localparam int NUMW  = NW;           // divider dividend width
    localparam int DENW  = DETW;         // divider divisor width
    localparam int CCW   = NUMW + 2;     // unclamped center width
    localparam int OW    = 40;           // output field width
    localparam int LW    = 39;           // clamp limit width
    localparam int DXH   = OW - BL;      // high part of a distance
    localparam int SUMW  = 2 * OW + 2;   // squared radius, even width
    localparam int RTW   = SUMW / 2;     // root width and step count
    localparam int RW    = RTW + 3;      // root remainder width
    localparam int CFGIW = 1;

    localparam logic [CFGIW-1:0] REG_CLAMP_LIMIT = 1'd0;
    localparam logic [CFGIW-1:0] REG_DEGEN_VALUE = 1'd1;

    localparam logic [LW-1:0]        LIMIT_RESET = {LW{1'b1}};
    localparam logic signed [OW-1:0] DEGEN_RESET = -(40'sd99999 <<< FB);

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        logic   degen;
        logic   neg_x;
        logic   neg_y;
    } t_dside;

    typedef struct packed {
        logic signed [OW-1:0] cx;
        logic signed [OW-1:0] cy;
        logic                 degen;
        logic                 clamped;
    } t_res;

endpackage
`default_nettype wire

// ----- src/tc_in_if.sv -----
// Input channel of the circumcircle block: one triangle per request.
// Depends on tc_pkg.
`default_nettype none
interface tc_in_if;
    import tc_pkg::*;
    logic   valid;
    logic   ready;
    t_coord ax;
    t_coord ay;
    t_coord bx;
    t_coord by;
    t_coord cx;
    t_coord cy;
    modport source(output valid, ax, ay, bx, by, cx, cy, input ready);
    modport sink(input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface
`default_nettype wire

// ----- src/tc_out_if.sv -----
// Output channel of the circumcircle block: center, radius and flags.
// Depends on tc_pkg.
`default_nettype none
interface tc_out_if;
    import tc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [OW-1:0] center_x;
    logic signed [OW-1:0] center_y;
    logic [OW-1:0]        radius;
    logic                 degenerate;
    logic                 clamped;
    modport source(output valid, center_x, center_y, radius, degenerate, clamped,
                   input ready);
    modport sink(input valid, center_x, center_y, radius, degenerate, clamped,
                 output ready);
endinterface
`default_nettype wire

// ----- src/tc_front.sv -----
// Front pipeline: vertex differences, determinant, squared lengths and the
// two numerators, ending in the dividend and divisor magnitudes. Uses tc_pkg.
`default_nettype none
module tc_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    tc_in_if.sink                     i_in,
    output logic                      o_valid,
    output logic [tc_pkg::NUMW-1:0]   o_num_x,
    output logic [tc_pkg::NUMW-1:0]   o_num_y,
    output logic [tc_pkg::DENW-1:0]   o_den,
    output tc_pkg::t_dside            o_side
);
    import tc_pkg::*;

    function automatic logic signed [NW-1:0] join_pp(input logic signed [PHW-1:0] h,
                                                     input logic signed [PLW-1:0] l);
        join_pp = (NW'(h) <<< BL) + NW'(l);
    endfunction

    logic [5:0] r_v;

    t_coord r1_ax, r1_ay, r2_ax, r2_ay, r3_ax, r3_ay, r4_ax, r4_ay, r5_ax, r5_ay;
    logic signed [DW-1:0] r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [DW-1:0] r2_bx, r2_by, r2_cx, r2_cy;
    logic signed [DW-1:0] r3_bx, r3_by, r3_cx, r3_cy;
    logic signed [PW-1:0] r2_pbc, r2_pbcx, r2_bx2, r2_by2, r2_cx2, r2_cy2;
    logic signed [DETW-1:0] r3_d, r4_d, r5_d;
    logic [SQW-1:0] r3_bb, r3_cc;
    logic signed [PHW-1:0] r4_bcy_h, r4_cby_h, r4_cbx_h, r4_bcx_h;
    logic signed [PLW-1:0] r4_bcy_l, r4_cby_l, r4_cbx_l, r4_bcx_l;
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic r5_degen;
    logic [NUMW-1:0] r6_num_x, r6_num_y;
    logic [DENW-1:0] r6_den;
    t_dside r6_side;

    logic signed [DETW-1:0] n3_d;
    logic [NW-1:0] n6_ax, n6_ay;
    logic [DETW-1:0] n6_ad;

    assign i_in.ready = i_en;

    assign n3_d = (DETW'(r2_pbc) - DETW'(r2_pbcx)) <<< 1;
    assign n6_ax = r5_nx[NW-1] ? NW'(-r5_nx) : NW'(r5_nx);
    assign n6_ay = r5_ny[NW-1] ? NW'(-r5_ny) : NW'(r5_ny);
    assign n6_ad = r5_d[DETW-1] ? DETW'(-r5_d) : DETW'(r5_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_in.valid};
        end
        if (i_en) begin
            r1_ax <= i_in.ax;
            r1_ay <= i_in.ay;
            r1_bx <= DW'(i_in.bx) - DW'(i_in.ax);
            r1_by <= DW'(i_in.by) - DW'(i_in.ay);
            r1_cx <= DW'(i_in.cx) - DW'(i_in.ax);
            r1_cy <= DW'(i_in.cy) - DW'(i_in.ay);

            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_pbc  <= r1_bx * r1_cy;
            r2_pbcx <= r1_by * r1_cx;
            r2_bx2  <= r1_bx * r1_bx;
            r2_by2  <= r1_by * r1_by;
            r2_cx2  <= r1_cx * r1_cx;
            r2_cy2  <= r1_cy * r1_cy;

            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
            r3_bx <= r2_bx;
            r3_by <= r2_by;
            r3_cx <= r2_cx;
            r3_cy <= r2_cy;
            r3_d  <= n3_d;
            r3_bb <= SQW'(r2_bx2[PW-2:0]) + SQW'(r2_by2[PW-2:0]);
            r3_cc <= SQW'(r2_cx2[PW-2:0]) + SQW'(r2_cy2[PW-2:0]);

            // Squared lengths exceed 32 bits, so each product is split in two.
            r4_ax    <= r3_ax;
            r4_ay    <= r3_ay;
            r4_d     <= r3_d;
            r4_bcy_h <= $signed({1'b0, r3_bb[SQW-1:BL]}) * r3_cy;
            r4_bcy_l <= $signed({1'b0, r3_bb[BL-1:0]}) * r3_cy;
            r4_cby_h <= $signed({1'b0, r3_cc[SQW-1:BL]}) * r3_by;
            r4_cby_l <= $signed({1'b0, r3_cc[BL-1:0]}) * r3_by;
            r4_cbx_h <= $signed({1'b0, r3_cc[SQW-1:BL]}) * r3_bx;
            r4_cbx_l <= $signed({1'b0, r3_cc[BL-1:0]}) * r3_bx;
            r4_bcx_h <= $signed({1'b0, r3_bb[SQW-1:BL]}) * r3_cx;
            r4_bcx_l <= $signed({1'b0, r3_bb[BL-1:0]}) * r3_cx;

            r5_ax    <= r4_ax;
            r5_ay    <= r4_ay;
            r5_d     <= r4_d;
            r5_degen <= (r4_d == '0);
            r5_nx    <= join_pp(r4_bcy_h, r4_bcy_l) - join_pp(r4_cby_h, r4_cby_l);
            r5_ny    <= join_pp(r4_cbx_h, r4_cbx_l) - join_pp(r4_bcx_h, r4_bcx_l);

            // Round to nearest with ties away from zero: (2|n| + |d|) / (2|d|).
            r6_num_x      <= NUMW'({n6_ax, 1'b0}) + NUMW'(n6_ad);
            r6_num_y      <= NUMW'({n6_ay, 1'b0}) + NUMW'(n6_ad);
            r6_den        <= {n6_ad[DETW-2:0], 1'b0};
            r6_side.ax    <= r5_ax;
            r6_side.ay    <= r5_ay;
            r6_side.degen <= r5_degen;
            r6_side.neg_x <= r5_nx[NW-1] ^ r5_d[DETW-1];
            r6_side.neg_y <= r5_ny[NW-1] ^ r5_d[DETW-1];
        end
    end

    assign o_valid = r_v[5];
    assign o_num_x = r6_num_x;
    assign o_num_y = r6_num_y;
    assign o_den   = r6_den;
    assign o_side  = r6_side;

endmodule
`default_nettype wire

// ----- src/tc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with an x and a
// y lane sharing one divisor. Uses tc_pkg.
`default_nettype none
module tc_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [tc_pkg::NUMW-1:0] i_num_x,
    input  wire logic [tc_pkg::NUMW-1:0] i_num_y,
    input  wire logic [tc_pkg::DENW-1:0] i_den,
    input  tc_pkg::t_dside            i_side,
    output logic                      o_valid,
    output logic [tc_pkg::NUMW-1:0]   o_q_x,
    output logic [tc_pkg::NUMW-1:0]   o_q_y,
    output tc_pkg::t_dside            o_side
);
    import tc_pkg::*;

    logic            r_v     [NUMW];
    logic [DENW-1:0] r_rem_x [NUMW];
    logic [DENW-1:0] r_rem_y [NUMW];
    logic [NUMW-1:0] r_nq_x  [NUMW];
    logic [NUMW-1:0] r_nq_y  [NUMW];
    logic [DENW-1:0] r_den   [NUMW];
    t_dside          r_side  [NUMW];

    for (genvar g = 0; g < NUMW; g++) begin : g_stage
        logic            a_v;
        logic [DENW-1:0] a_rem_x, a_rem_y, a_den;
        logic [NUMW-1:0] a_nq_x, a_nq_y;
        t_dside          a_side;
        logic [DENW:0]   t_x, t_y;

        if (g == 0) begin : g_first
            assign a_v     = i_valid;
            assign a_rem_x = '0;
            assign a_rem_y = '0;
            assign a_nq_x  = i_num_x;
            assign a_nq_y  = i_num_y;
            assign a_den   = i_den;
            assign a_side  = i_side;
        end else begin : g_next
            assign a_v     = r_v[g-1];
            assign a_rem_x = r_rem_x[g-1];
            assign a_rem_y = r_rem_y[g-1];
            assign a_nq_x  = r_nq_x[g-1];
            assign a_nq_y  = r_nq_y[g-1];
            assign a_den   = r_den[g-1];
            assign a_side  = r_side[g-1];
        end

        // The dividend shifts out at the top while quotient bits enter below.
        assign t_x = {a_rem_x, a_nq_x[NUMW-1]};
        assign t_y = {a_rem_y, a_nq_y[NUMW-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= a_v;
            end
            if (i_en) begin
                r_den[g]  <= a_den;
                r_side[g] <= a_side;
                if (t_x >= {1'b0, a_den}) begin
                    r_rem_x[g] <= DENW'(t_x - {1'b0, a_den});
                    r_nq_x[g]  <= {a_nq_x[NUMW-2:0], 1'b1};
                end else begin
                    r_rem_x[g] <= DENW'(t_x);
                    r_nq_x[g]  <= {a_nq_x[NUMW-2:0], 1'b0};
                end
                if (t_y >= {1'b0, a_den}) begin
                    r_rem_y[g] <= DENW'(t_y - {1'b0, a_den});
                    r_nq_y[g]  <= {a_nq_y[NUMW-2:0], 1'b1};
                end else begin
                    r_rem_y[g] <= DENW'(t_y);
                    r_nq_y[g]  <= {a_nq_y[NUMW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[NUMW-1];
    assign o_q_x   = r_nq_x[NUMW-1];
    assign o_q_y   = r_nq_y[NUMW-1];
    assign o_side  = r_side[NUMW-1];

endmodule
`default_nettype wire

// ----- src/tc_sqrt.sv -----
// Radius pipeline: squares the two distances in split partial products,
// sums them and takes the floor square root, two radicand bits per stage.
// Uses tc_pkg.
`default_nettype none
module tc_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [tc_pkg::OW-1:0] i_dx,
    input  wire logic [tc_pkg::OW-1:0] i_dy,
    input  tc_pkg::t_res            i_res,
    output logic                    o_valid,
    output logic [tc_pkg::RTW-1:0]  o_root,
    output tc_pkg::t_res            o_res
);
    import tc_pkg::*;

    logic [1:0]            r_v;
    logic [2*DXH-1:0]      r_hh_x, r_hh_y;
    logic [DXH+BL-1:0]     r_hl_x, r_hl_y;
    logic [2*BL-1:0]       r_ll_x, r_ll_y;
    t_res                  r_res_a, r_res_b;
    logic [SUMW-1:0]       r_sum;

    logic            r_sv   [RTW];
    logic [RW-1:0]   r_rem  [RTW];
    logic [RTW-1:0]  r_root [RTW];
    logic [SUMW-1:0] r_rad  [RTW];
    t_res            r_sres [RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
        if (i_en) begin
            r_hh_x  <= i_dx[OW-1:BL] * i_dx[OW-1:BL];
            r_hl_x  <= i_dx[OW-1:BL] * i_dx[BL-1:0];
            r_ll_x  <= i_dx[BL-1:0] * i_dx[BL-1:0];
            r_hh_y  <= i_dy[OW-1:BL] * i_dy[OW-1:BL];
            r_hl_y  <= i_dy[OW-1:BL] * i_dy[BL-1:0];
            r_ll_y  <= i_dy[BL-1:0] * i_dy[BL-1:0];
            r_res_a <= i_res;
            r_sum   <= (SUMW'(r_hh_x) << (2 * BL)) + (SUMW'(r_hl_x) << (BL + 1))
                     + SUMW'(r_ll_x)
                     + (SUMW'(r_hh_y) << (2 * BL)) + (SUMW'(r_hl_y) << (BL + 1))
                     + SUMW'(r_ll_y);
            r_res_b <= r_res_a;
        end
    end

    for (genvar g = 0; g < RTW; g++) begin : g_stage
        logic            a_v;
        logic [RW-1:0]   a_rem;
        logic [RTW-1:0]  a_root;
        logic [SUMW-1:0] a_rad;
        t_res            a_res;
        logic [RW-1:0]   t_rem, t_trial;

        if (g == 0) begin : g_first
            assign a_v    = r_v[1];
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_rad  = r_sum;
            assign a_res  = r_res_b;
        end else begin : g_next
            assign a_v    = r_sv[g-1];
            assign a_rem  = r_rem[g-1];
            assign a_root = r_root[g-1];
            assign a_rad  = r_rad[g-1];
            assign a_res  = r_sres[g-1];
        end

        assign t_rem   = {a_rem[RW-3:0], a_rad[SUMW-1:SUMW-2]};
        assign t_trial = RW'({a_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g] <= 1'b0;
            end else if (i_en) begin
                r_sv[g] <= a_v;
            end
            if (i_en) begin
                r_rad[g]  <= {a_rad[SUMW-3:0], 2'b00};
                r_sres[g] <= a_res;
                if (t_rem >= t_trial) begin
                    r_rem[g]  <= t_rem - t_trial;
                    r_root[g] <= {a_root[RTW-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= t_rem;
                    r_root[g] <= {a_root[RTW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_sv[RTW-1];
    assign o_root  = r_root[RTW-1];
    assign o_res   = r_sres[RTW-1];

endmodule
`default_nettype wire

// ----- src/triangle_circumcircle.sv -----
// Triangle circumcircle: center and radius of three vertices, fully pipelined.
// Stages: 6 front stages, 76 divider stages (one quotient bit each), 3 center and
// clamp stages, 43 radius stages (41 root bits) and the output register.
// Throughput one triangle per cycle; a stalled output holds the whole pipeline.
// Synchronous active-low reset clears all valid bits and restores the registers.
// Depends on tc_pkg, tc_in_if, tc_out_if, tc_front, tc_div and tc_sqrt.
`default_nettype none
module triangle_circumcircle (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [tc_pkg::CFGIW-1:0] i_cfg_idx,
    input  wire logic [tc_pkg::OW-1:0] i_cfg_data,
    tc_in_if.sink                      i_in,
    tc_out_if.source                   o_out
);
    import tc_pkg::*;

    logic en;

    logic [LW-1:0]        r_limit;
    logic signed [OW-1:0] r_degen;

    logic            f_valid;
    logic [NUMW-1:0] f_num_x, f_num_y;
    logic [DENW-1:0] f_den;
    t_dside          f_side;

    logic            d_valid;
    logic [NUMW-1:0] d_q_x, d_q_y;
    t_dside          d_side;

    logic [2:0]            r_v;
    logic signed [CCW-1:0] r7_cx, r7_cy;
    logic                  r7_degen;
    t_coord                r7_ax, r7_ay, r8_ax, r8_ay;
    t_res                  r8_res, r9_res;
    logic [OW-1:0]         r9_dx, r9_dy;

    logic signed [CCW-1:0] n7_qx, n7_qy;
    logic [CCW-1:0]        n8_mx, n8_my;
    logic                  n8_ox, n8_oy;
    logic signed [OW:0]    n9_ex, n9_ey;

    logic           s_valid;
    logic [RTW-1:0] s_root;
    t_res           s_res;

    logic                 r_out_v;
    t_res                 r_out_res;
    logic [OW-1:0]        r_out_rad;

    assign en = !r_out_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_degen <= DEGEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLAMP_LIMIT: r_limit <= i_cfg_data[LW-1:0];
                REG_DEGEN_VALUE: r_degen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_num_x (f_num_x),
        .o_num_y (f_num_y),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    tc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_num_x (f_num_x),
        .i_num_y (f_num_y),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_q_x   (d_q_x),
        .o_q_y   (d_q_y),
        .o_side  (d_side)
    );

    assign n7_qx = d_side.neg_x ? -$signed({2'b00, d_q_x}) : $signed({2'b00, d_q_x});
    assign n7_qy = d_side.neg_y ? -$signed({2'b00, d_q_y}) : $signed({2'b00, d_q_y});

    assign n8_mx = r7_cx[CCW-1] ? CCW'(-r7_cx) : CCW'(r7_cx);
    assign n8_my = r7_cy[CCW-1] ? CCW'(-r7_cy) : CCW'(r7_cy);
    assign n8_ox = n8_mx > CCW'(r_limit);
    assign n8_oy = n8_my > CCW'(r_limit);

    assign n9_ex = (OW+1)'(r8_ax) - (OW+1)'(r8_res.cx);
    assign n9_ey = (OW+1)'(r8_ay) - (OW+1)'(r8_res.cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], d_valid};
        end
        if (en) begin
            // A collinear triangle takes the configured center instead of the quotient.
            r7_ax    <= d_side.ax;
            r7_ay    <= d_side.ay;
            r7_degen <= d_side.degen;
            r7_cx    <= d_side.degen ? CCW'(r_degen) : CCW'(d_side.ax) + n7_qx;
            r7_cy    <= d_side.degen ? CCW'(r_degen) : CCW'(d_side.ay) + n7_qy;

            r8_ax          <= r7_ax;
            r8_ay          <= r7_ay;
            r8_res.cx      <= n8_ox ? $signed({1'b0, r_limit}) : r7_cx[OW-1:0];
            r8_res.cy      <= n8_oy ? $signed({1'b0, r_limit}) : r7_cy[OW-1:0];
            r8_res.degen   <= r7_degen;
            r8_res.clamped <= n8_ox || n8_oy;

            r9_res <= r8_res;
            r9_dx  <= n9_ex[OW] ? OW'(-n9_ex) : OW'(n9_ex);
            r9_dy  <= n9_ey[OW] ? OW'(-n9_ey) : OW'(n9_ey);
        end
    end

    tc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[2]),
        .i_dx    (r9_dx),
        .i_dy    (r9_dy),
        .i_res   (r9_res),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_res   (s_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= s_valid;
        end
        if (en) begin
            r_out_res <= s_res;
            r_out_rad <= s_root[RTW-1] ? {OW{1'b1}} : s_root[OW-1:0];
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.center_x   = r_out_res.cx;
    assign o_out.center_y   = r_out_res.cy;
    assign o_out.radius     = r_out_rad;
    assign o_out.degenerate = r_out_res.degen;
    assign o_out.clamped    = r_out_res.clamped;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for triangle_circumcircle: random and directed triangles, a bit-exact
// circumcircle predictor in a scoreboard class, and idling on both channels.
// Depends on tc_pkg, tc_in_if, tc_out_if and the block itself.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tc_pkg::*;

    typedef struct packed {
        t_coord ax, ay, bx, by, cx, cy;
    } t_tri;

    typedef struct packed {
        logic signed [OW-1:0] cx;
        logic signed [OW-1:0] cy;
        logic [OW-1:0]        radius;
        logic                 degen;
        logic                 clamped;
    } t_circle;

    typedef logic signed [127:0] t_wide;

    class circle_scoreboard;
        t_circle                expected_circles[$];
        logic [LW-1:0]          clamp_limit;
        logic signed [OW-1:0]   degen_value;
        int                     mismatches;

        function new();
            clamp_limit = LIMIT_RESET;
            degen_value = DEGEN_RESET;
            mismatches  = 0;
        endfunction

        // Quotient rounded to nearest, ties away from zero.
        function t_wide round_div(t_wide n, t_wide d);
            t_wide an, ad, q;
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q  = (2 * an + ad) / (2 * ad);
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function t_wide limit_comp(t_wide v, inout logic flag);
            t_wide lim, av;
            lim = {89'b0, clamp_limit};
            av  = (v < 0) ? -v : v;
            if (av > lim) begin
                flag = 1'b1;
                return lim;
            end
            return v;
        endfunction

        function t_circle circumcircle(t_tri t);
            t_wide ax, ay, bxr, byr, cxr, cyr, det, bb, cc, ux, uy, dx, dy;
            logic [127:0] sum, root, trial;
            t_circle r;
            ax  = t.ax;
            ay  = t.ay;
            bxr = t_wide'(t.bx) - ax;
            byr = t_wide'(t.by) - ay;
            cxr = t_wide'(t.cx) - ax;
            cyr = t_wide'(t.cy) - ay;
            det = 2 * (bxr * cyr - byr * cxr);
            r.clamped = 1'b0;
            r.degen   = (det == 0);
            if (r.degen) begin
                ux = degen_value;
                uy = degen_value;
            end else begin
                bb = bxr * bxr + byr * byr;
                cc = cxr * cxr + cyr * cyr;
                ux = ax + round_div(bb * cyr - cc * byr, det);
                uy = ay + round_div(cc * bxr - bb * cxr, det);
            end
            ux = limit_comp(ux, r.clamped);
            uy = limit_comp(uy, r.clamped);
            dx = ax - ux;
            dy = ay - uy;
            sum = dx * dx + dy * dy;
            root = 0;
            for (int b = 45; b >= 0; b--) begin
                trial = root | (128'd1 << b);
                if (trial * trial <= sum) root = trial;
            end
            r.radius = (root > 128'hFF_FFFF_FFFF) ? '1 : root[OW-1:0];
            r.cx = ux[OW-1:0];
            r.cy = uy[OW-1:0];
            return r;
        endfunction

        function void note_triangle(t_tri t);
            expected_circles.push_back(circumcircle(t));
        endfunction

        function void check_circle(t_circle got);
            t_circle want;
            if (expected_circles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result cx=%0d cy=%0d r=%0d", got.cx, got.cy,
                             got.radius);
                return;
            end
            want = expected_circles.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp cx=%0d cy=%0d r=%0d dg=%b cl=%b, ",
                              "got cx=%0d cy=%0d r=%0d dg=%b cl=%b"},
                             want.cx, want.cy, want.radius, want.degen, want.clamped,
                             got.cx, got.cy, got.radius, got.degen, got.clamped);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFGIW-1:0]  i_cfg_idx;
    logic [OW-1:0]     i_cfg_data;

    tc_in_if  in_if();
    tc_out_if out_if();

    triangle_circumcircle i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    circle_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    bit backpressure_req;
    int hold_left;
    int cycle_count;

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_CLAMP_LIMIT;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.ax     = '0;
        in_if.ay     = '0;
        in_if.bx     = '0;
        in_if.by     = '0;
        in_if.cx     = '0;
        in_if.cy     = '0;
        out_if.ready = 1'b0;
        tx_idle_pct  = 32;
        rx_idle_pct  = 56;
        backpressure_req = 1'b0;
        hold_left    = 0;
        cycle_count  = 0;
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin
        if (backpressure_req) begin
            backpressure_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_triangle({in_if.ax, in_if.ay, in_if.bx, in_if.by, in_if.cx, in_if.cy});
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_circle({out_if.center_x, out_if.center_y, out_if.radius,
                             out_if.degenerate, out_if.clamped});
    end

    task automatic send_triangle(t_tri t);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.ax <= t.ax;
        in_if.ay <= t.ay;
        in_if.bx <= t.bx;
        in_if.by <= t.by;
        in_if.cx <= t.cx;
        in_if.cy <= t.cy;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.expected_circles.size() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFGIW-1:0] idx, logic [OW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_CLAMP_LIMIT)
            sb.clamp_limit = value[LW-1:0];
        else
            sb.degen_value = value;
    endtask

    function automatic t_coord rand_coord(int kind);
        case (kind)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(8191) - 4096);
            default: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
        endcase
    endfunction

    function automatic t_tri random_triangle();
        t_tri t;
        int kind, k;
        kind = $urandom_range(1);
        t.ax = rand_coord(kind);
        t.ay = rand_coord(kind);
        t.bx = rand_coord(kind);
        t.by = rand_coord(kind);
        t.cx = rand_coord(kind);
        t.cy = rand_coord(kind);
        case ($urandom_range(9))
            0: begin
                // Collinear: C sits on the line through A and B.
                k = $urandom_range(6) - 3;
                t.bx = t_coord'(t.ax + $urandom_range(63) - 32);
                t.by = t_coord'(t.ay + $urandom_range(63) - 32);
                t.cx = t_coord'(t.ax + k * (t.bx - t.ax));
                t.cy = t_coord'(t.ay + k * (t.by - t.ay));
            end
            1: begin
                // Nearly collinear: the center lands far away.
                t.cx = t.bx + (t.bx - t.ax);
                t.cy = t_coord'(t.by + (t.by - t.ay) + 1);
            end
            2: begin
                t.cx = t.ax;
                t.cy = t.ay;
            end
            3: t.cx = rand_coord(2);
            default: ;
        endcase
        return t;
    endfunction

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2 && tx_idle_pct == 0) backpressure_req = 1'b1;
            send_triangle(random_triangle());
        end
        drain();
    endtask

    localparam t_coord CMAX = 24'sh7FFFFF;
    localparam t_coord CMIN = -24'sh800000;

    initial begin
        t_tri directed[$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back('{0, 0, 0, 0, 0, 0});
        directed.push_back('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
        directed.push_back('{CMIN, CMIN, CMAX, CMIN, CMIN, CMAX});
        directed.push_back('{CMAX, CMAX, CMIN, CMAX, CMAX, CMIN});
        directed.push_back('{CMIN, CMAX, CMAX, CMIN, CMAX, CMAX});
        directed.push_back('{CMIN, CMIN, CMAX, CMAX, 0, 0});
        directed.push_back('{CMIN, CMIN, CMAX, CMAX, 1, 0});
        directed.push_back('{0, 0, 256, 0, 0, 256});
        directed.push_back('{0, 0, 1, 0, 0, 1});
        directed.push_back('{0, 0, 3, 0, 0, 1});
        directed.push_back('{-5, 7, -5, 7, 100, -3});
        directed.push_back('{10, 20, 30, 40, 50, 60});
        directed.push_back('{CMIN, 0, 0, 0, CMAX, 1});
        directed.push_back('{0, CMIN, 1, 0, 0, CMAX});
        directed.push_back('{-1, -1, 1, 1, -1, 1});
        directed.push_back('{1000, -2000, -3000, 4000, 5000, 6000});
        foreach (directed[i]) send_triangle(directed[i]);
        drain();

        random_phase(280);

        tx_idle_pct = 56;
        rx_idle_pct = 32;
        write_reg(REG_CLAMP_LIMIT, 40'd256000);
        write_reg(REG_DEGEN_VALUE, 40'd0);
        foreach (directed[i]) send_triangle(directed[i]);
        random_phase(280);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(REG_CLAMP_LIMIT, 40'd0);
        write_reg(REG_DEGEN_VALUE, 40'sh7F_FFFF_FFFF);
        random_phase(280);

        write_reg(REG_CLAMP_LIMIT, {1'b1, {LW{1'b1}}});
        write_reg(REG_DEGEN_VALUE, 40'sh80_0000_0000);
        foreach (directed[i]) send_triangle(directed[i]);
        random_phase(280);

        if (sb.mismatches == 0 && sb.expected_circles.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
